### hdl/rmo_pkg.sv
// Package with the width parameters for the orthonormalizer.
`default_nettype none
package rmo_pkg;
  localparam int unsigned DataWidth  = 18;
  localparam int unsigned FracBits   = 15;
  localparam int unsigned MinLenBits = 17;
endpackage
`default_nettype wire

### hdl/rmo_if.sv
// Valid/ready channel interface carrying a vector of signed elements.
`default_nettype none
interface rmo_if #(
  parameter int unsigned N = 6,
  parameter int unsigned W = 18
);
  logic valid;
  logic ready;
  logic signed [W-1:0] data [N];
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/rmo_sqrt_cell.sv
// One restoring square-root cell: settles one result bit and passes the rest on.
`default_nettype none
module rmo_sqrt_cell #(
  parameter int unsigned RW = 38,
  parameter int unsigned SHIFT = 0
) (
  input  wire  logic          clk_i,
  input  wire  logic          en_i,
  input  wire  logic [RW-1:0] rem_i,
  input  wire  logic [RW-1:0] res_i,
  output logic [RW-1:0]       rem_o,
  output logic [RW-1:0]       res_o
);
  logic [RW-1:0] bit_w, trial_w, rem_d, res_d, rem_q, res_q;
  assign bit_w   = RW'(1) << (2 * SHIFT);
  assign trial_w = res_i + bit_w;
  always_comb begin
    if (rem_i >= trial_w) begin
      rem_d = rem_i - trial_w;
      res_d = (res_i >> 1) + bit_w;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end
  // The cell's stage register moves with the pipeline.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end
  assign rem_o = rem_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

### hdl/rmo_div_cell.sv
// One restoring divider cell: settles one quotient bit of a magnitude division.
`default_nettype none
module rmo_div_cell #(
  parameter int unsigned QW = 32,
  parameter int unsigned DW = 20,
  parameter int unsigned POS = 0
) (
  input  wire  logic          clk_i,
  input  wire  logic          en_i,
  input  wire  logic [QW-1:0] num_i,
  input  wire  logic [DW-1:0] den_i,
  input  wire  logic [DW:0]   rem_i,
  output logic [QW-1:0]       num_o,
  output logic [DW-1:0]       den_o,
  output logic [DW:0]         rem_o
);
  logic [DW+1:0] sh_w, sub_w;
  logic [DW:0]   rem_d;
  logic [QW-1:0] num_d, num_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_q;
  assign sh_w  = {rem_i, num_i[POS]};
  assign sub_w = sh_w - {2'b00, den_i};
  always_comb begin
    num_d = num_i;
    if (!sub_w[DW+1]) begin
      rem_d      = sub_w[DW:0];
      num_d[POS] = 1'b1;
    end else begin
      rem_d      = sh_w[DW:0];
      num_d[POS] = 1'b0;
    end
  end
  // Quotient bits replace numerator bits in place as they settle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_i;
      rem_q <= rem_d;
    end
  end
  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
endmodule
`default_nettype wire

### hdl/rmo_norm.sv
// Vector normalizer: squares, square-root cell chain, then three divider chains.
`default_nettype none
module rmo_norm #(
  parameter int unsigned DATA_WIDTH = rmo_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = rmo_pkg::FracBits
) (
  input  wire  logic                         clk_i,
  input  wire  logic                         en_i,
  input  wire  logic [rmo_pkg::MinLenBits-1:0] min_len_i,
  input  wire  logic signed [DATA_WIDTH-1:0] v_i [3],
  input  wire  logic signed [DATA_WIDTH+1:0] side_i [3],
  output logic signed [DATA_WIDTH-1:0]       v_o [3],
  output logic signed [DATA_WIDTH+1:0]       side_o [3]
);
  localparam int unsigned SW  = 2 * DATA_WIDTH + 2;
  localparam int unsigned RB  = SW / 2;
  localparam int unsigned NW  = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned LW  = RB + 1;
  localparam int unsigned TOT = 1 + RB + 1 + NW;
  localparam logic signed [DATA_WIDTH-1:0] EMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] EMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Data delay lines for the vector and side values, one stage per stage ahead of the output.
  logic signed [DATA_WIDTH-1:0] vd_q [TOT][3];
  logic signed [DATA_WIDTH+1:0] sd_q [TOT][3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vd_q[0] <= v_i;
      sd_q[0] <= side_i;
      for (int s = 1; s < TOT; s++) begin
        vd_q[s] <= vd_q[s-1];
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  // Sum of squares.
  logic [SW-1:0] sq_q;
  logic [DATA_WIDTH-1:0] a_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) a_w[i] = v_i[i][DATA_WIDTH-1] ? DATA_WIDTH'(-v_i[i])
                                                              : DATA_WIDTH'(v_i[i]);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) sq_q <= SW'(a_w[0] * a_w[0]) + SW'(a_w[1] * a_w[1]) + SW'(a_w[2] * a_w[2]);
  end

  // Square-root cell chain.
  logic [SW-1:0] rem_w [RB+1];
  logic [SW-1:0] res_w [RB+1];
  assign rem_w[0] = sq_q;
  assign res_w[0] = '0;
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    rmo_sqrt_cell #(.RW(SW), .SHIFT(RB - 1 - k)) u_cell (
      .clk_i, .en_i, .rem_i(rem_w[k]), .res_i(res_w[k]),
      .rem_o(rem_w[k+1]), .res_o(res_w[k+1]));
  end

  // Threshold decision and divider inputs.
  logic [LW-1:0] len_q;
  logic          do_q;
  logic [NW-1:0] mag_q [3];
  logic          neg_q [3];
  logic [LW-1:0] len_w;
  assign len_w = res_w[RB][LW-1:0];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= len_w;
      do_q  <= len_w > LW'(min_len_i);
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= vd_q[RB][i][DATA_WIDTH-1];
        mag_q[i] <= NW'(vd_q[RB][i][DATA_WIDTH-1] ? -vd_q[RB][i] : vd_q[RB][i]) << FRAC_BITS;
      end
    end
  end

  // Divider cell chains, one per element.
  logic [NW-1:0] q_w [3];
  logic do_w [NW+1];
  logic neg_w [NW+1][3];
  assign do_w[0] = do_q;
  assign neg_w[0] = neg_q;
  for (genvar e = 0; e < 3; e++) begin : g_lane
    logic [NW-1:0] n_w [NW+1];
    logic [LW-1:0] d_w [NW+1];
    logic [LW:0]   r_w [NW+1];
    assign n_w[0] = mag_q[e];
    assign d_w[0] = len_q;
    assign r_w[0] = '0;
    for (genvar k = 0; k < NW; k++) begin : g_div
      rmo_div_cell #(.QW(NW), .DW(LW), .POS(NW - 1 - k)) u_cell (
        .clk_i, .en_i, .num_i(n_w[k]), .den_i(d_w[k]), .rem_i(r_w[k]),
        .num_o(n_w[k+1]), .den_o(d_w[k+1]), .rem_o(r_w[k+1]));
    end
    assign q_w[e] = n_w[NW];
  end
  for (genvar k = 0; k < NW; k++) begin : g_ctl
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        do_w[k+1]  <= do_w[k];
        neg_w[k+1] <= neg_w[k];
      end
    end
  end

  // Sign and saturation, or pass-through for short columns.
  logic signed [DATA_WIDTH-1:0] r_q [3];
  logic signed [DATA_WIDTH+1:0] side_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= sd_q[TOT-1];
      for (int i = 0; i < 3; i++) begin
        if (!do_w[NW]) r_q[i] <= vd_q[TOT-1][i];
        else if (!neg_w[NW][i])
          r_q[i] <= (q_w[i] > NW'(EMax)) ? EMax : DATA_WIDTH'(q_w[i]);
        else
          r_q[i] <= (q_w[i] > NW'(EMax) + NW'(1)) ? EMin : DATA_WIDTH'(-q_w[i]);
      end
    end
  end
  assign v_o    = r_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

### hdl/rotation_matrix_orthonormalize.sv
// Top level: 3x3 Gram-Schmidt orthonormalizer built from square-root and divider cell chains.
//  channel | dir | handshake   | payload
//  in_if   | in  | valid/ready | col0_row0..col1_row2
//  out_if  | out | valid/ready | res_col0_row0..res_col2_row2
// One matrix enters per cycle while the pipeline advances. The pipeline holds two
// normalizers (square, one square-root cell per result bit, setup, one divider
// cell per quotient bit, saturation) plus five stages for the dot product,
// projection and cross product. The whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset clears the valid bits only; min_length resets to zero.
`default_nettype none
module rotation_matrix_orthonormalize #(
  parameter int unsigned DATA_WIDTH = rmo_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = rmo_pkg::FracBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [rmo_pkg::MinLenBits-1:0] cfg_wdata_i,
  rmo_if.sink   in_if,
  rmo_if.source out_if
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned NW = W + FRAC_BITS;
  localparam int unsigned NLAT = 1 + SW / 2 + 1 + NW + 1;
  localparam int unsigned LAT = 2 * NLAT + 5;
  localparam logic signed [W-1:0] EMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] EMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+1:0] DLim = (W+2)'((2 ** W) - 1);

  logic [rmo_pkg::MinLenBits-1:0] min_len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_len_q <= '0;
    else if (cfg_we_i) min_len_q <= cfg_wdata_i;
  end

  // Pipeline advance and valid chain.
  logic en_w;
  logic [LAT-1:0] vld_q;
  assign en_w = !out_if.valid || out_if.ready;
  assign in_if.ready = en_w;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_w) vld_q <= {vld_q[LAT-2:0], in_if.valid};
  end

  function automatic logic signed [W-1:0] sat_f(input logic signed [2*W+3:0] v);
    if (v > (2*W+4)'(EMax)) return EMax;
    if (v < (2*W+4)'(EMin)) return EMin;
    return W'(v);
  endfunction
  // Truncating shift toward zero by FRAC_BITS.
  function automatic logic signed [2*W+3:0] tdiv_f(input logic signed [2*W+3:0] v);
    logic signed [2*W+3:0] b;
    b = v;
    if (v < 0) b = v + (2*W+4)'((2 ** FRAC_BITS) - 1);
    return b >>> FRAC_BITS;
  endfunction

  // First normalizer: x, with y carried alongside.
  logic signed [W-1:0] x_in_w [3], x_w [3];
  logic signed [W+1:0] y_in_w [3], y_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_in_w[i] = in_if.data[i];
      y_in_w[i] = (W+2)'(in_if.data[3+i]);
    end
  end
  rmo_norm #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_nx (
    .clk_i, .en_i(en_w), .min_len_i(min_len_q), .v_i(x_in_w), .side_i(y_in_w),
    .v_o(x_w), .side_o(y_w));

  // Dot product stage: products then scaled sum with clamp.
  logic signed [2*W+3:0] pd_q [3];
  logic signed [W-1:0] x1_q [3], x2_q [3];
  logic signed [W+1:0] y1_q [3], dot_q;
  logic signed [2*W+3:0] dsum_w;
  always_comb begin
    dsum_w = tdiv_f(pd_q[0] + pd_q[1] + pd_q[2]);
  end
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      for (int i = 0; i < 3; i++) pd_q[i] <= (2*W+4)'(x_w[i] * y_w[i]);
      x1_q <= x_w;
      y1_q <= y_w;
      x2_q <= x1_q;
      if (dsum_w > (2*W+4)'(DLim)) dot_q <= DLim;
      else if (dsum_w < -(2*W+4)'(DLim)) dot_q <= -DLim;
      else dot_q <= (W+2)'(dsum_w);
    end
  end
  // Projection removal, registered ahead of the second normalizer's squares.
  logic signed [W+1:0] y2_q [3];
  logic signed [W-1:0] yp_q [3], yn_w [3];
  logic signed [W+1:0] xs_q [3], xo_w [3];
  always_ff @(posedge clk_i) begin
    if (en_w) y2_q <= y1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      for (int i = 0; i < 3; i++) begin
        yp_q[i] <= sat_f((2*W+4)'(y2_q[i]) - tdiv_f((2*W+4)'(dot_q * x2_q[i])));
        xs_q[i] <= (W+2)'(x2_q[i]);
      end
    end
  end
  // Second normalizer: y, with x carried alongside.
  rmo_norm #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_ny (
    .clk_i, .en_i(en_w), .min_len_i(min_len_q), .v_i(yp_q), .side_i(xs_q),
    .v_o(yn_w), .side_o(xo_w));

  // Cross product: products, then scaled differences.
  logic signed [2*W+3:0] cp_q [6];
  logic signed [W-1:0] xf_q [3], yf_q [3];
  logic signed [W-1:0] res_q [9];
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      cp_q[0] <= (2*W+4)'(xo_w[1] * yn_w[2]);
      cp_q[1] <= (2*W+4)'(xo_w[2] * yn_w[1]);
      cp_q[2] <= (2*W+4)'(xo_w[2] * yn_w[0]);
      cp_q[3] <= (2*W+4)'(xo_w[0] * yn_w[2]);
      cp_q[4] <= (2*W+4)'(xo_w[0] * yn_w[1]);
      cp_q[5] <= (2*W+4)'(xo_w[1] * yn_w[0]);
      for (int i = 0; i < 3; i++) begin
        xf_q[i] <= W'(xo_w[i]);
        yf_q[i] <= yn_w[i];
      end
      for (int i = 0; i < 3; i++) begin
        res_q[i]   <= xf_q[i];
        res_q[3+i] <= yf_q[i];
        res_q[6+i] <= sat_f(tdiv_f(cp_q[2*i] - cp_q[2*i+1]));
      end
    end
  end
  assign out_if.valid = vld_q[LAT-1];
  assign out_if.data  = res_q;

  // A transfer out implies the pipeline was advancing.
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready) |-> in_if.ready) else $error("advance mismatch");
  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("result lost");
  // Nothing leaves unless something was accepted long enough ago.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |=> !(out_if.valid && $past(!in_if.valid))) else $error("invented");
endmodule
`default_nettype wire
